// ===== sv/bsmc_pkg.sv =====
package bsmc_pkg;

    // Default number of fraction bits of gains and filter state.
    localparam int FRAC_BITS_DEFAULT = 8;

    // Fraction bits of the pitch angle and the angle setpoint.
    localparam int ANGLE_FRAC = 8;

    // Shared multiplier: 24 bit gain times a 32 bit signed operand.
    localparam int GAIN_W = 24;
    localparam int MULB_W = 32;
    localparam int PROD_W = GAIN_W + MULB_W;

    // Quotient bits produced per step of the divide-by-ten unit.
    localparam int DIV_RADIX = 6;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BAL_KP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAL_KD    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPD_KP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPD_KI    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INT_LIMIT = 3'd5;

    // Multiplier operand selects.
    typedef enum logic [1:0] {
        A_BAL_KP,
        A_BAL_KD,
        A_SPD_KP,
        A_SPD_KI
    } mul_a_t;

    typedef enum logic [1:0] {
        B_ERR,
        B_RATE,
        B_FILT,
        B_INTEG
    } mul_b_t;

    // Accumulator operations.
    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SHIFT,
        ACC_NUM,
        ACC_DIV
    } acc_op_t;

    // Arithmetic right shift applied on the way into the accumulator.
    typedef enum logic [1:0] {
        SH_NONE,
        SH_FRAC,
        SH_ANGLE,
        SH_TWICE
    } shift_t;

    // Sequencer branch conditions: taken goes to the target, else to the next step.
    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_NO_INPUT,
        J_DIV_MORE,
        J_OUT_BUSY
    } jump_t;

    typedef logic [3:0] step_t;

    // Microprogram addresses.
    localparam step_t STEP_IDLE    = 4'd0;
    localparam step_t STEP_MUL_P   = 4'd1;
    localparam step_t STEP_MUL_D   = 4'd2;
    localparam step_t STEP_ADD_D   = 4'd3;
    localparam step_t STEP_BAL_NUM = 4'd4;
    localparam step_t STEP_DIV     = 4'd5;
    localparam step_t STEP_FILT    = 4'd6;
    localparam step_t STEP_INTEG   = 4'd7;
    localparam step_t STEP_MUL_I   = 4'd8;
    localparam step_t STEP_ADD_I   = 4'd9;
    localparam step_t STEP_SCALE   = 4'd10;
    localparam step_t STEP_WAIT    = 4'd11;
    localparam step_t STEP_OUT     = 4'd12;

    // One control word of the microprogram.
    typedef struct packed {
        logic    take_in;
        logic    mul_en;
        mul_a_t  mul_a;
        mul_b_t  mul_b;
        acc_op_t acc_op;
        shift_t  shift;
        logic    wr_bal;
        logic    wr_filt;
        logic    wr_integ;
        logic    wr_out;
        jump_t   jump;
        step_t   target;
    } uword_t;

    // Control store.
    function automatic uword_t ucode(input step_t s);
        uword_t w;
        w = '0;
        unique case (s)
            STEP_IDLE:
            begin
                w.take_in = 1'b1;
                w.jump    = J_NO_INPUT;
                w.target  = STEP_IDLE;
            end
            STEP_MUL_P:
            begin
                w.mul_en = 1'b1;
                w.mul_a  = A_BAL_KP;
                w.mul_b  = B_ERR;
            end
            STEP_MUL_D:
            begin
                w.mul_en = 1'b1;
                w.mul_a  = A_BAL_KD;
                w.mul_b  = B_RATE;
                w.acc_op = ACC_LOAD;
                w.shift  = SH_ANGLE;
            end
            STEP_ADD_D:
            begin
                w.acc_op = ACC_ADD;
                w.shift  = SH_FRAC;
            end
            STEP_BAL_NUM:
            begin
                w.wr_bal = 1'b1;
                w.acc_op = ACC_NUM;
            end
            STEP_DIV:
            begin
                w.acc_op = ACC_DIV;
                w.jump   = J_DIV_MORE;
                w.target = STEP_DIV;
            end
            STEP_FILT:
            begin
                w.wr_filt = 1'b1;
            end
            STEP_INTEG:
            begin
                w.wr_integ = 1'b1;
                w.mul_en   = 1'b1;
                w.mul_a    = A_SPD_KP;
                w.mul_b    = B_FILT;
            end
            STEP_MUL_I:
            begin
                w.mul_en = 1'b1;
                w.mul_a  = A_SPD_KI;
                w.mul_b  = B_INTEG;
                w.acc_op = ACC_LOAD;
                w.shift  = SH_NONE;
            end
            STEP_ADD_I:
            begin
                w.acc_op = ACC_ADD;
                w.shift  = SH_NONE;
            end
            STEP_SCALE:
            begin
                w.acc_op = ACC_SHIFT;
                w.shift  = SH_TWICE;
            end
            STEP_WAIT:
            begin
                w.jump   = J_OUT_BUSY;
                w.target = STEP_WAIT;
            end
            STEP_OUT:
            begin
                w.wr_out = 1'b1;
                w.jump   = J_ALWAYS;
                w.target = STEP_IDLE;
            end
            default:
            begin
                w.jump   = J_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== sv/balance_speed_motor_controller_core.sv =====
// Channel   Handshake             Payload
// input     in_valid / in_stall   pitch_angle, pitch_rate, left_encoder, right_encoder
// output    out_valid / out_stall balance_part, speed_part, motor_drive
// config    cfg_we                cfg_index, cfg_data
//
// A result is registered as the sequencer returns to idle, and no new input is accepted
// until then: four products share one multiplier and a divide by ten resolves six
// quotient bits per cycle.
// Reset is asynchronous; it loads the register defaults and clears the filter state.
// A stalled output holds the sequencer in its wait step; the next input can be accepted
// in the idle step that follows, while the result sits in the output register.
module balance_speed_motor_controller_core #(
    parameter int FRAC_BITS = bsmc_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [15:0]                pitch_angle,
    input  logic signed [15:0]                pitch_rate,
    input  logic signed [15:0]                left_encoder,
    input  logic signed [15:0]                right_encoder,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [15:0]                balance_part,
    output logic signed [15:0]                speed_part,
    output logic signed [15:0]                motor_drive,
    input  logic                              cfg_we,
    input  logic [bsmc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bsmc_pkg::GAIN_W-1:0]       cfg_data
);

    // Filter numerator: speed scaled by 2^F plus nine times the old filter value.
    localparam int NUM_W   = (FRAC_BITS + 18 > 37) ? FRAC_BITS + 18 : 37;
    localparam int MAG_W   = NUM_W - 1;
    localparam int DIV_W   = ((MAG_W + bsmc_pkg::DIV_RADIX - 1) / bsmc_pkg::DIV_RADIX)
                             * bsmc_pkg::DIV_RADIX;
    localparam int DIV_STEPS = DIV_W / bsmc_pkg::DIV_RADIX;
    localparam int CNT_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam int ACC_W   = (DIV_W > bsmc_pkg::PROD_W + 2) ? DIV_W : bsmc_pkg::PROD_W + 2;
    localparam int RADIX   = bsmc_pkg::DIV_RADIX;

    // Saturate an accumulator value to signed 16 bits.
    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic fits;
        fits = (&v[ACC_W-1:15]) | ~(|v[ACC_W-1:15]);
        if (fits)
            return v[15:0];
        else if (v[ACC_W-1])
            return 16'sh8000;
        else
            return 16'sh7fff;
    endfunction

    // Configuration registers.
    logic signed [23:0] bal_kp_reg;
    logic signed [23:0] bal_kd_reg;
    logic signed [23:0] spd_kp_reg;
    logic signed [23:0] spd_ki_reg;
    logic signed [15:0] angle_ofs_reg;
    logic [22:0]        lim_reg;

    // Sequencer and datapath.
    bsmc_pkg::step_t     step_reg;
    bsmc_pkg::step_t     step_next;
    bsmc_pkg::uword_t    uw;
    logic [CNT_W-1:0]    div_cnt_reg;
    logic [CNT_W-1:0]    div_cnt_next;
    logic [3:0]          rem_reg;
    logic [3:0]          rem_next;
    logic                neg_reg;
    logic                neg_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [bsmc_pkg::PROD_W-1:0] prod_reg;
    logic signed [31:0]  filt_reg;
    logic signed [31:0]  filt_next;
    logic signed [23:0]  integ_reg;
    logic signed [23:0]  integ_next;
    logic signed [15:0]  bal_reg;

    // Latched transaction.
    logic signed [15:0]  angle_reg;
    logic signed [15:0]  rate_reg;
    logic signed [15:0]  left_reg;
    logic signed [15:0]  right_reg;

    // Output register.
    logic                out_valid_reg;
    logic signed [15:0]  bal_out_reg;
    logic signed [15:0]  spd_out_reg;
    logic signed [15:0]  drive_out_reg;

    logic                in_fire;
    logic                out_busy;
    logic                div_more;
    logic signed [16:0]  err;
    logic signed [16:0]  speed;
    logic signed [23:0]  mul_a_op;
    logic signed [31:0]  mul_b_op;
    logic signed [ACC_W-1:0] sh_src;
    logic signed [ACC_W-1:0] shifted;
    logic signed [NUM_W-1:0] num;
    logic [MAG_W-1:0]    mag;
    logic [RADIX-1:0]    qbits;
    logic signed [DIV_W:0] f_wide;
    logic signed [32:0]  integ_sum;
    logic signed [32:0]  lim_pos;
    logic signed [32:0]  lim_neg;
    logic signed [15:0]  spd16;
    logic signed [16:0]  drive_sum;
    logic signed [15:0]  drive16;

    assign uw       = bsmc_pkg::ucode(step_reg);
    assign in_stall = ~uw.take_in;
    assign in_fire  = in_valid & ~in_stall;
    assign out_busy = out_valid_reg & out_stall;
    assign div_more = div_cnt_reg != CNT_W'(DIV_STEPS - 1);

    assign out_valid    = out_valid_reg;
    assign balance_part = bal_out_reg;
    assign speed_part   = spd_out_reg;
    assign motor_drive  = drive_out_reg;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bal_kp_reg    <= -24'sd102400;
            bal_kd_reg    <= '0;
            spd_kp_reg    <= '0;
            spd_ki_reg    <= '0;
            angle_ofs_reg <= 16'sd1280;
            lim_reg       <= 23'd2560000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bsmc_pkg::CFG_BAL_KP:    bal_kp_reg    <= cfg_data;
                bsmc_pkg::CFG_BAL_KD:    bal_kd_reg    <= cfg_data;
                bsmc_pkg::CFG_SPD_KP:    spd_kp_reg    <= cfg_data;
                bsmc_pkg::CFG_SPD_KI:    spd_ki_reg    <= cfg_data;
                bsmc_pkg::CFG_ANGLE_OFS: angle_ofs_reg <= cfg_data[15:0];
                bsmc_pkg::CFG_INT_LIMIT: lim_reg       <= cfg_data[22:0];
                default:
                begin
                end
            endcase
        end
    end

    // Step counter with conditional jumps.
    always_comb
    begin
        unique case (uw.jump)
            bsmc_pkg::J_ALWAYS:   step_next = uw.target;
            bsmc_pkg::J_NO_INPUT: step_next = in_valid ? step_reg + 4'd1 : uw.target;
            bsmc_pkg::J_DIV_MORE: step_next = div_more ? uw.target : step_reg + 4'd1;
            bsmc_pkg::J_OUT_BUSY: step_next = out_busy ? uw.target : step_reg + 4'd1;
            default:              step_next = step_reg + 4'd1;
        endcase
    end

    // Operands derived from the latched transaction.
    assign err   = 17'(angle_reg) - 17'(angle_ofs_reg);
    assign speed = 17'(right_reg) - 17'(left_reg);

    // Shared multiplier operand selection.
    always_comb
    begin
        unique case (uw.mul_a)
            bsmc_pkg::A_BAL_KP: mul_a_op = bal_kp_reg;
            bsmc_pkg::A_BAL_KD: mul_a_op = bal_kd_reg;
            bsmc_pkg::A_SPD_KP: mul_a_op = spd_kp_reg;
            default:            mul_a_op = spd_ki_reg;
        endcase
        unique case (uw.mul_b)
            bsmc_pkg::B_ERR:  mul_b_op = 32'(err);
            bsmc_pkg::B_RATE: mul_b_op = 32'(rate_reg);
            bsmc_pkg::B_FILT: mul_b_op = filt_reg;
            default:          mul_b_op = 32'(integ_reg);
        endcase
    end

    // Flooring shift of the product, or of the accumulator itself.
    always_comb
    begin
        sh_src = (uw.acc_op == bsmc_pkg::ACC_SHIFT) ? acc_reg : ACC_W'(prod_reg);
        unique case (uw.shift)
            bsmc_pkg::SH_NONE:  shifted = sh_src;
            bsmc_pkg::SH_FRAC:  shifted = sh_src >>> FRAC_BITS;
            bsmc_pkg::SH_ANGLE: shifted = sh_src >>> (bsmc_pkg::ANGLE_FRAC + FRAC_BITS);
            default:            shifted = sh_src >>> (2 * FRAC_BITS);
        endcase
    end

    // Filter numerator, folded to a non-negative magnitude; floor division of a
    // negative value is the complement of the quotient of its complement.
    assign num = (NUM_W'(speed) <<< FRAC_BITS) + (NUM_W'(filt_reg) <<< 3) + NUM_W'(filt_reg);
    assign mag = num[NUM_W-1] ? ~num[MAG_W-1:0] : num[MAG_W-1:0];

    // Divide-by-ten step: several restoring long-division bits per cycle.
    always_comb
    begin
        logic [4:0] trial;
        logic [3:0] r;
        r = rem_reg;
        qbits = '0;
        for (int k = 0; k < RADIX; k++)
        begin
            trial = {r, acc_reg[DIV_W-1-k]};
            if (trial >= 5'd10)
            begin
                qbits[RADIX-1-k] = 1'b1;
                r = 4'(trial - 5'd10);
            end
            else
            begin
                r = trial[3:0];
            end
        end
        rem_next = r;
    end

    // Accumulator and division bookkeeping.
    always_comb
    begin
        acc_next     = acc_reg;
        div_cnt_next = div_cnt_reg;
        neg_next     = neg_reg;
        unique case (uw.acc_op)
            bsmc_pkg::ACC_LOAD:  acc_next = shifted;
            bsmc_pkg::ACC_ADD:   acc_next = acc_reg + shifted;
            bsmc_pkg::ACC_SHIFT: acc_next = shifted;
            bsmc_pkg::ACC_NUM:
            begin
                acc_next             = '0;
                acc_next[MAG_W-1:0]  = mag;
                neg_next             = num[NUM_W-1];
                div_cnt_next         = '0;
            end
            bsmc_pkg::ACC_DIV:
            begin
                acc_next             = '0;
                acc_next[DIV_W-1:0]  = {acc_reg[DIV_W-RADIX-1:0], qbits};
                div_cnt_next         = div_cnt_reg + CNT_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // New filter value: signed quotient saturated to 32 bits.
    always_comb
    begin
        f_wide = neg_reg ? ~{1'b0, acc_reg[DIV_W-1:0]} : {1'b0, acc_reg[DIV_W-1:0]};
        if ((&f_wide[DIV_W:31]) | ~(|f_wide[DIV_W:31]))
            filt_next = f_wide[31:0];
        else if (f_wide[DIV_W])
            filt_next = 32'sh80000000;
        else
            filt_next = 32'sh7fffffff;
    end

    // Running integral clamped to the symmetric limit.
    assign lim_pos   = 33'($unsigned(lim_reg));
    assign lim_neg   = -lim_pos;
    assign integ_sum = 33'(integ_reg) + 33'(filt_reg);
    always_comb
    begin
        priority if (integ_sum > lim_pos)
            integ_next = lim_pos[23:0];
        else if (integ_sum < lim_neg)
            integ_next = lim_neg[23:0];
        else
            integ_next = integ_sum[23:0];
    end

    // Final speed term and saturated drive sum.
    assign spd16     = sat16(acc_reg);
    assign drive_sum = 17'(bal_reg) + 17'(spd16);
    assign drive16   = (drive_sum[16] != drive_sum[15])
                     ? (drive_sum[16] ? 16'sh8000 : 16'sh7fff)
                     : drive_sum[15:0];

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= bsmc_pkg::STEP_IDLE;
            div_cnt_reg   <= '0;
            rem_reg       <= '0;
            filt_reg      <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg    <= step_next;
            div_cnt_reg <= div_cnt_next;
            if (uw.acc_op == bsmc_pkg::ACC_NUM)
                rem_reg <= '0;
            else if (uw.acc_op == bsmc_pkg::ACC_DIV)
                rem_reg <= rem_next;
            if (uw.wr_filt)
                filt_reg <= filt_next;
            if (uw.wr_integ)
                integ_reg <= integ_next;
            if (uw.wr_out)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        neg_reg <= neg_next;
        if (uw.mul_en)
            prod_reg <= mul_a_op * mul_b_op;
        if (uw.wr_bal)
            bal_reg <= sat16(acc_reg);
        if (in_fire)
        begin
            angle_reg <= pitch_angle;
            rate_reg  <= pitch_rate;
            left_reg  <= left_encoder;
            right_reg <= right_encoder;
        end
        if (uw.wr_out)
        begin
            bal_out_reg   <= bal_reg;
            spd_out_reg   <= spd16;
            drive_out_reg <= drive16;
        end
    end

    // The division remainder stays a decimal digit.
    a_rem_digit: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 4'd9)
        else $error("divider remainder out of range");

    // After an update the integral lies within the configured limit.
    a_integ_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        $past(uw.wr_integ) |-> (33'(integ_reg) <= lim_pos && 33'(integ_reg) >= lim_neg))
        else $error("speed integral outside its limit");

    // A result is written only into a free or draining output register.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        uw.wr_out |-> !(out_valid_reg && out_stall))
        else $error("result overwrote a stalled output");

    // An accepted transaction starts the program at its first multiply.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> step_reg == bsmc_pkg::STEP_MUL_P)
        else $error("sequencer did not start after acceptance");

endmodule
